/* hw/rtl/sts_pkg.sv */
package sts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned LOC_W           = 7;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned APB_DW          = 32;
  localparam int unsigned PADDR_W         = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SEARCH = 2'd2
  } sts_kind_e;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_BINARY = 1'b1
  } sts_mode_e;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_SEARCH_MODE = 1'b0
  } sts_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sts_state_e;

endpackage

/* hw/rtl/sorted_table_search.sv */
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    kind_i, value_i
// out       source     out_valid_o / out_stall_i  found_o, location_o, overflow_o
// config    APB slave  psel/penable/pwrite/pready search_mode at byte address 0
//
// Clear and append transactions give no result.
// A search probes the table memory once per cycle (one read, one compare):
// binary mode halves the search range with each probe, linear mode steps
// through the filled entries in order until a hit or the last entry.
// Reset empties the table at once; no sweep of the memory is needed.
// A finished search waits in its own state while the output register is
// still held by a stall; input is stalled until the search is handed over.
module sorted_table_search #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sts_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [sts_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [sts_pkg::LOC_W-1:0]         location_o,
  output logic                              overflow_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sts_pkg::PADDR_W-1:0]       paddr,
  input  logic [sts_pkg::APB_DW-1:0]        pwdata,
  output logic [sts_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import sts_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BW   = AW + 2;

  sts_state_e state_q, state_d;

  logic [CNTW-1:0]         count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic                    mode_q;
  logic signed [BW-1:0]    lo_q, hi_q;
  logic [AW-1:0]           idx_q;
  logic [DATA_W-1:0]       key_q;
  logic                    res_found_q, res_found_d;
  logic [LOC_W-1:0]        res_loc_q, res_loc_d;
  logic                    res_ovf_q;
  logic                    out_valid_q;
  logic                    found_q, ovf_out_q;
  logic [LOC_W-1:0]        loc_q;

  logic                    in_acc, out_free, cfg_wr;
  logic                    is_search, is_append, is_clear, tbl_full, tbl_empty;
  logic                    hit, miss, cmp_gt;
  logic signed [BW-1:0]    idx_s, nlo, nhi, start_hi, probe_lo, probe_hi, probe_sum;
  logic [AW-1:0]           probe_addr;
  logic                    ram_we, ram_re;
  logic [DATA_W-1:0]       ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_search  = (kind_i == KIND_SEARCH);
  assign is_append  = (kind_i == KIND_APPEND);
  assign is_clear   = (kind_i == KIND_CLEAR);
  assign tbl_full   = (count_q == CNTW'(TABLE_DEPTH));
  assign tbl_empty  = (count_q == '0);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SEARCH_MODE) ? APB_DW'(mode_q) : '0;

  // probe evaluation
  assign hit      = (ram_rdata == key_q);
  assign cmp_gt   = ($signed(ram_rdata) > $signed(key_q));
  assign idx_s    = signed'(BW'(idx_q));
  assign nlo      = (mode_q == MODE_BINARY && cmp_gt) ? lo_q : idx_s + BW'(1);
  assign nhi      = (mode_q == MODE_BINARY && cmp_gt) ? idx_s - BW'(1) : hi_q;
  assign miss     = (nlo > nhi);
  assign start_hi = signed'(BW'(count_q) - BW'(1));

  always_comb begin
    if (state_q == ST_IDLE) begin
      probe_lo = '0;
      probe_hi = start_hi;
    end else begin
      probe_lo = nlo;
      probe_hi = nhi;
    end
  end

  assign probe_sum  = probe_lo + probe_hi;
  assign probe_addr = (mode_q == MODE_BINARY) ? probe_sum[AW:1] : probe_lo[AW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_search) begin
          state_d = tbl_empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    count_d     = count_q;
    ovf_d       = ovf_q;
    res_found_d = res_found_q;
    res_loc_d   = res_loc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_clear) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else if (is_append) begin
            if (tbl_full) begin
              ovf_d = 1'b1;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CNTW'(1);
            end
          end else if (is_search) begin
            ram_re      = !tbl_empty;
            res_found_d = 1'b0;
            res_loc_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_loc_d   = LOC_W'(idx_q);
        end else if (miss) begin
          res_found_d = 1'b0;
          res_loc_d   = '0;
        end else begin
          ram_re = 1'b1;
        end
      end
      default: ;
    endcase
  end

  sts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (probe_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= MODE_BINARY;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cfg_wr && paddr[2] == REG_SEARCH_MODE) begin
        mode_q <= pwdata[0];
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_loc_q   <= res_loc_d;
    if (ram_re) begin
      lo_q  <= probe_lo;
      hi_q  <= probe_hi;
      idx_q <= probe_addr;
    end
    if (in_acc) begin
      key_q     <= value_i;
      res_ovf_q <= ovf_q;
    end
    if (state_q == ST_DONE && out_free) begin
      found_q   <= res_found_q;
      loc_q     <= res_loc_q;
      ovf_out_q <= res_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign location_o  = loc_q;
  assign overflow_o  = ovf_out_q;

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(TABLE_DEPTH))
    else $error("element count beyond table depth");

  a_scan_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (hi_q < signed'(BW'(count_q)) && lo_q >= 0))
    else $error("search bounds outside filled part");

  a_done_handover : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished search not handed to output");

  a_scan_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && state_d == ST_SCAN) |-> ram_re)
    else $error("search continues without a probe");

endmodule

/* hw/rtl/sts_ram.sv */
module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
